/* design/wdcs_pkg.sv */
// wdcs_pkg: types, codes and constants shared by the WAV chunk streamer
// used by wdcs_parse, wdcs_gain and wav_data_chunk_stream_gain_top
package wdcs_pkg;

	localparam int HDR_WIN   = 256;
	localparam int HS_W      = $clog2(HDR_WIN);
	localparam int MAGIC_LEN = 4;
	localparam int HDR_START = 12;
	localparam int HDR_LEN   = 8;

	localparam logic [31:0] DATA_TAG   = 32'h6174_6164;
	localparam logic [7:0]  GAIN_RESET = 8'd10;

	// floor(a / 100) = (a * DIV_M) >> DIV_SH for a below 2^23
	localparam logic [23:0] DIV_M  = 24'd10737419;
	localparam int          DIV_SH = 30;

	localparam logic [16:0] SAT_POS = 17'd32767;
	localparam logic [16:0] SAT_NEG = 17'd32768;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MAGIC,
		PH_FORM,
		PH_HDR,
		PH_SKIP,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		RC_SAMPLE   = 2'd0,
		RC_NOT_RIFF = 2'd1,
		RC_NO_DATA  = 2'd2
	} rcode_t;

	typedef struct packed {
		rcode_t             kind;
		logic signed [15:0] raw;
		logic               last;
	} item_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h52;
			2'd1:    b = 8'h49;
			default: b = 8'h46;
		endcase
		return b;
	endfunction

endpackage

/* design/wav_data_chunk_stream_gain_top.sv */
// wav_data_chunk_stream_gain_top: WAV byte stream to gained stereo samples
// depends on wdcs_pkg, wdcs_parse and wdcs_gain
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata in_byte, tuser file_start
// m_axis    out  m_axis_tvalid/tready    tdata left/right, tuser result_code, tlast
// cfg       in   cfg_valid/cfg_ready     cfg_data gain_percent
//
// one byte beat per cycle while the output is not stalled; a taken byte's result passes
// through input register, parse, gain multiply, divide partial products and output
// reset restores gain_percent to 10 and idles the parser until a file start
// a stalled output lets empty stages fill; beats that make no result pass only while the gain stage takes items
// cfg_ready is always high
module wav_data_chunk_stream_gain_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	input  logic [0:0]  s_axis_tuser,  // file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // left_sample, right_sample
	output logic [1:0]  m_axis_tuser,  // result_code
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import wdcs_pkg::*;

	logic [7:0] gain_pct_q;
	logic       item_valid, item_ready;
	item_t      item;
	rcode_t     out_kind;
	logic signed [15:0] out_sample;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_pct_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_pct_q <= cfg_data;
		end
	end

	wdcs_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_start   (s_axis_tuser[0]),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	wdcs_gain u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain       (gain_pct_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (out_kind),
		.out_sample (out_sample),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {out_sample, out_sample};
	assign m_axis_tuser = out_kind;

endmodule

/* design/wdcs_parse.sv */
// wdcs_parse: input register and RIFF chunk walker, pairs data bytes into samples
// depends on wdcs_pkg
module wdcs_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_start,
	output logic           item_valid,
	input  logic           item_ready,
	output wdcs_pkg::item_t item
);
	import wdcs_pkg::*;

	localparam bit FORM_NO_ROOM = (HDR_START + HDR_LEN >= HDR_WIN);
	localparam logic [33:0] HS_LIM = 34'(HDR_WIN - HDR_LEN);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        fire;

	phase_t      ph_q, ph_d, ph_e;
	logic [3:0]  off_q, off_d, off_e;
	logic        bad_q, bad_d, bad_e, bad_n;
	logic [63:0] hdr_q, hdr_d, hdr_n;
	logic [31:0] skip_q, skip_d;
	logic [31:0] rem_q, rem_d, rem_n;
	logic [7:0]  low_q, low_d;
	logic        par_q, par_d;
	logic [HS_W-1:0] hs_q, hs_d;
	logic [33:0] nhs;
	logic        res;

	assign in_ready = !v_s1 || item_ready;
	assign fire     = v_s1 && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= in_start;
		end
	end

	assign ph_e  = start_s1 ? PH_MAGIC : ph_q;
	assign off_e = start_s1 ? 4'd0 : off_q;
	assign bad_e = start_s1 ? 1'b0 : bad_q;
	assign bad_n = bad_e || (byte_s1 != magic_byte(off_e[1:0]));
	assign hdr_n = {byte_s1, hdr_q[63:8]};
	assign rem_n = rem_q - 32'd1;
	assign nhs   = 34'(hs_q) + 34'(HDR_LEN) + {2'b00, hdr_n[63:32]};

	// next state
	always_comb begin
		ph_d   = ph_e;
		off_d  = off_e;
		bad_d  = bad_e;
		hdr_d  = hdr_q;
		skip_d = skip_q;
		rem_d  = rem_q;
		low_d  = low_q;
		par_d  = par_q;
		hs_d   = hs_q;
		case (ph_e)
			PH_MAGIC: begin
				bad_d = bad_n;
				off_d = off_e + 4'd1;
				if (off_e == 4'(MAGIC_LEN - 1)) begin
					ph_d = bad_n ? PH_DONE : PH_FORM;
				end
			end
			PH_FORM: begin
				off_d = off_e + 4'd1;
				if (off_e == 4'(HDR_START - 1)) begin
					hs_d  = HS_W'(HDR_START);
					off_d = 4'd0;
					ph_d  = FORM_NO_ROOM ? PH_DONE : PH_HDR;
				end
			end
			PH_HDR: begin
				hdr_d = hdr_n;
				off_d = off_e + 4'd1;
				if (off_e == 4'(HDR_LEN - 1)) begin
					off_d = 4'd0;
					if (hdr_n[31:0] == DATA_TAG) begin
						rem_d = hdr_n[63:32];
						par_d = 1'b0;
						ph_d  = (hdr_n[63:32] == 32'd0) ? PH_DONE : PH_DATA;
					end else if (nhs >= HS_LIM) begin
						ph_d = PH_DONE;
					end else begin
						hs_d   = nhs[HS_W-1:0];
						skip_d = hdr_n[63:32];
						ph_d   = (hdr_n[63:32] == 32'd0) ? PH_HDR : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (skip_q != 32'd0) begin
					skip_d = skip_q - 32'd1;
				end
				if (skip_q <= 32'd1) begin
					off_d = 4'd0;
					ph_d  = PH_HDR;
				end
			end
			PH_DATA: begin
				if (rem_q == 32'd0) begin
					ph_d = PH_DONE;
				end else begin
					rem_d = rem_n;
					par_d = !par_q;
					if (!par_q) begin
						low_d = byte_s1;
					end
					if (rem_n == 32'd0) begin
						ph_d = PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result of this beat
	always_comb begin
		res       = 1'b0;
		item.kind = RC_SAMPLE;
		item.raw  = '0;
		item.last = 1'b0;
		case (ph_e)
			PH_MAGIC: begin
				if (off_e == 4'(MAGIC_LEN - 1) && bad_n) begin
					res       = 1'b1;
					item.kind = RC_NOT_RIFF;
				end
			end
			PH_FORM: begin
				if (off_e == 4'(HDR_START - 1) && FORM_NO_ROOM) begin
					res       = 1'b1;
					item.kind = RC_NO_DATA;
				end
			end
			PH_HDR: begin
				if (off_e == 4'(HDR_LEN - 1)) begin
					if (hdr_n[31:0] == DATA_TAG) begin
						res = (hdr_n[63:32] == 32'd0);
					end else begin
						res = (nhs >= HS_LIM);
					end
					item.kind = RC_NO_DATA;
				end
			end
			PH_DATA: begin
				if (rem_q != 32'd0 && par_q) begin
					res       = 1'b1;
					item.raw  = $signed({byte_s1, low_q});
					item.last = (rem_n < 32'd2);
				end
			end
			default: begin
			end
		endcase
	end

	assign item_valid = v_s1 && res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			off_q  <= 4'd0;
			bad_q  <= 1'b0;
			hdr_q  <= '0;
			skip_q <= '0;
			rem_q  <= '0;
			low_q  <= '0;
			par_q  <= 1'b0;
			hs_q   <= '0;
		end else if (fire) begin
			ph_q   <= ph_d;
			off_q  <= off_d;
			bad_q  <= bad_d;
			hdr_q  <= hdr_d;
			skip_q <= skip_d;
			rem_q  <= rem_d;
			low_q  <= low_d;
			par_q  <= par_d;
			hs_q   <= hs_d;
		end
	end

endmodule

/* design/wdcs_gain.sv */
// wdcs_gain: gain multiply, divide by 100, saturation and output register
// depends on wdcs_pkg
module wdcs_gain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      gain,
	input  logic            item_valid,
	output logic            item_ready,
	input  wdcs_pkg::item_t item,
	output logic            out_valid,
	input  logic            out_ready,
	output wdcs_pkg::rcode_t out_kind,
	output logic signed [15:0] out_sample,
	output logic            out_last
);
	import wdcs_pkg::*;

	logic v_s2, v_s3, v_s4;
	logic adv_o, adv_s4, adv_s3, adv_s2;

	item_t              it_s2;
	logic signed [24:0] prod_s3;
	rcode_t             kind_s3, kind_s4;
	logic               last_s3, last_s4;
	logic               neg_s4;
	logic [34:0]        pph_s4;
	logic [35:0]        ppl_s4;

	logic [24:0] pv, mag;
	logic [46:0] sum;
	logic [16:0] q, nq;
	logic signed [15:0] sat;

	assign adv_o      = !out_valid || out_ready;
	assign adv_s4     = !v_s4 || adv_o;
	assign adv_s3     = !v_s3 || adv_s4;
	assign adv_s2     = !v_s2 || adv_s3;
	assign item_ready = adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s2) v_s2 <= item_valid;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_o) out_valid <= v_s4;
		end
	end

	assign pv  = prod_s3;
	assign mag = pv[24] ? (~pv + 25'd1) : pv;

	assign sum = {pph_s4, 12'd0} + {11'd0, ppl_s4};
	assign q   = sum[46:DIV_SH];
	assign nq  = 17'd0 - q;

	always_comb begin
		if (neg_s4) begin
			sat = (q > SAT_NEG) ? -16'sd32768 : $signed(nq[15:0]);
		end else begin
			sat = (q > SAT_POS) ? 16'sd32767 : $signed(q[15:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && item_valid) begin
			it_s2 <= item;
		end
		if (adv_s3 && v_s2) begin
			prod_s3 <= it_s2.raw * $signed({1'b0, gain});
			kind_s3 <= it_s2.kind;
			last_s3 <= it_s2.last;
		end
		if (adv_s4 && v_s3) begin
			neg_s4  <= pv[24];
			pph_s4  <= mag[22:12] * DIV_M;
			ppl_s4  <= mag[11:0] * DIV_M;
			kind_s4 <= kind_s3;
			last_s4 <= last_s3;
		end
		if (adv_o && v_s4) begin
			out_kind   <= kind_s4;
			out_sample <= (kind_s4 == RC_SAMPLE) ? sat : 16'sd0;
			out_last   <= (kind_s4 == RC_SAMPLE) ? last_s4 : 1'b0;
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: random WAV byte streams through wav_data_chunk_stream_gain_top, checked beat by
// beat against an in-bench chunk parser and gain predictor, under several gain settings
// depends on wdcs_pkg and the design sources; reads no files
module testbench;
	import wdcs_pkg::*;

	localparam int          STALL_LIMIT = 5000;
	localparam int          DRAIN_WAIT  = 12;
	localparam int          IDLE_PCT    = 13;
	localparam int          PHASE_BYTES = 110;
	localparam logic [31:0] RIFF_WORD   = 32'h4646_4952;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} wav_beat_t;

	typedef struct packed {
		rcode_t      code;
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} stereo_out_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // left_sample, right_sample
	logic [1:0]  m_axis_tuser;  // result_code
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data      = '0;

	wav_beat_t   file_bytes[$];
	stereo_out_t pending_results[$];

	logic byte_fire = 1'b0;
	logic calm      = 1'b0;
	int   bytes_queued, bytes_taken, stray_bytes, gain_writes, files_sent;
	int   mismatches, samples_seen, lasts_seen, riff_errors, data_errors, quiet;

	// parser state
	phase_t          ps_phase     = PH_IDLE;
	int unsigned     ps_count     = 0;
	logic [63:0]     ps_hdr       = '0;
	logic [32:0]     ps_skip      = '0;
	logic [31:0]     ps_remain    = '0;
	logic [7:0]      ps_low       = '0;
	logic            ps_odd       = 1'b0;
	longint unsigned ps_chunk_at  = 0;
	logic            ps_bad_magic = 1'b0;
	logic [7:0]      gain_now     = GAIN_RESET;

	wav_data_chunk_stream_gain_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_error(input rcode_t kind);
		stereo_out_t r;
		r = '{code: kind, left: '0, right: '0, last: 1'b0};
		pending_results.push_back(r);
		ps_phase = PH_DONE;
	endtask

	task automatic start_header();
		ps_phase = PH_HDR;
		ps_count = 0;
		ps_hdr   = '0;
	endtask

	task automatic parse_wav_byte(input logic [7:0] b, input logic start);
		stereo_out_t r;
		logic [31:0] id, sz;
		int          scaled;
		if (start) begin
			ps_phase     = PH_MAGIC;
			ps_count     = 0;
			ps_hdr       = '0;
			ps_skip      = '0;
			ps_remain    = '0;
			ps_low       = '0;
			ps_odd       = 1'b0;
			ps_chunk_at  = 0;
			ps_bad_magic = 1'b0;
		end
		case (ps_phase)
			PH_MAGIC: begin
				if (b != RIFF_WORD[8 * (ps_count % 4) +: 8])
					ps_bad_magic = 1'b1;
				ps_count++;
				if (ps_count >= MAGIC_LEN) begin
					if (ps_bad_magic)
						flag_error(RC_NOT_RIFF);
					else
						ps_phase = PH_FORM;
				end
			end
			PH_FORM: begin
				ps_count++;
				if (ps_count >= HDR_START) begin
					ps_chunk_at = HDR_START;
					if (ps_chunk_at + HDR_LEN >= HDR_WIN)
						flag_error(RC_NO_DATA);
					else
						start_header();
				end
			end
			PH_HDR: begin
				ps_hdr[8 * (ps_count % 8) +: 8] = b;
				ps_count++;
				if (ps_count == HDR_LEN) begin
					id = ps_hdr[31:0];
					sz = ps_hdr[63:32];
					if (id == DATA_TAG) begin
						if (sz == 0) begin
							flag_error(RC_NO_DATA);
						end else begin
							ps_remain = sz;
							ps_odd    = 1'b0;
							ps_phase  = PH_DATA;
						end
					end else begin
						ps_chunk_at = ps_chunk_at + 64'(HDR_LEN) + 64'(sz);
						if (ps_chunk_at + HDR_LEN >= HDR_WIN) begin
							flag_error(RC_NO_DATA);
						end else begin
							ps_skip = {1'b0, sz};
							if (ps_skip == 0)
								start_header();
							else
								ps_phase = PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				if (ps_skip != 0)
					ps_skip--;
				if (ps_skip == 0)
					start_header();
			end
			PH_DATA: begin
				if (ps_remain == 0) begin
					ps_phase = PH_DONE;
				end else begin
					ps_remain--;
					if (!ps_odd) begin
						ps_low = b;
						ps_odd = 1'b1;
						if (ps_remain == 0)
							ps_phase = PH_DONE;
					end else begin
						ps_odd = 1'b0;
						scaled = int'($signed({b, ps_low})) * int'(gain_now) / 100;
						if (scaled > 32767)
							scaled = 32767;
						if (scaled < -32768)
							scaled = -32768;
						r = '{code: RC_SAMPLE, left: 16'(scaled), right: 16'(scaled),
							last: (ps_remain < 2)};
						pending_results.push_back(r);
						if (ps_remain == 0)
							ps_phase = PH_DONE;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic start = 1'b0);
		file_bytes.push_back('{start: start, data: b});
		bytes_queued++;
	endtask

	// little-endian, first byte optionally opens a new file
	task automatic send_word(input logic [31:0] w, input logic start = 1'b0);
		for (int k = 0; k < 4; k++)
			send_byte(w[8 * k +: 8], start && k == 0);
	endtask

	task automatic send_filler(input int n);
		for (int k = 0; k < n; k++)
			send_byte(8'($urandom()));
	endtask

	task automatic send_trailer();
		int n;
		n = $urandom_range(0, 2);
		send_filler(n);
		stray_bytes += n;
	endtask

	function automatic logic [31:0] other_tag();
		logic [31:0] t;
		if ($urandom_range(0, 4) == 0)
			t = DATA_TAG ^ (32'd1 << $urandom_range(0, 31));
		else
			t = $urandom();
		if (t == DATA_TAG)
			t ^= 32'd1;
		return t;
	endfunction

	task automatic send_skip_chunk(input int n);
		send_word(other_tag());
		send_word(n);
		send_filler(n);
	endtask

	task automatic send_pcm(input int n);
		logic [15:0] s;
		s = '0;
		for (int k = 0; k < n; k++) begin
			if (k % 2 == 0) begin
				case ($urandom_range(0, 7))
					0:       s = 16'h8000;
					1:       s = 16'h7fff;
					2:       s = 16'h0000;
					3:       s = 16'hffff;
					default: s = 16'($urandom());
				endcase
				send_byte(s[7:0]);
			end else begin
				send_byte(s[15:8]);
			end
		end
	endtask

	task automatic add_random_file();
		int          kind, n;
		logic [31:0] sz;
		kind = $urandom_range(0, 99);
		files_sent++;
		if (kind < 7) begin
			// magic with each byte possibly broken
			for (int k = 0; k < 4; k++)
				send_byte($urandom_range(0, 1) ? RIFF_WORD[8 * k +: 8] : 8'($urandom()), k == 0);
			send_trailer();
			return;
		end
		send_word(RIFF_WORD, 1'b1);
		send_filler(8);
		if (kind < 14) begin
			// next header would not fit inside the window
			case ($urandom_range(0, 2))
				0:       sz = 32'd228;
				1:       sz = 32'hffff_ffff;
				default: sz = $urandom() | 32'h100;
			endcase
			send_word(other_tag());
			send_word(sz);
			send_trailer();
		end else if (kind < 20) begin
			if ($urandom_range(0, 1))
				send_skip_chunk($urandom_range(0, 16));
			send_word(DATA_TAG);
			send_word(32'd0);
			send_trailer();
		end else if (kind < 27) begin
			send_filler($urandom_range(4, 30));
		end else if (kind < 31) begin
			// next header ending right at the window edge or one byte inside it
			send_skip_chunk($urandom_range(227, 228));
			n = $urandom_range(1, 9);
			send_word(DATA_TAG);
			send_word(n);
			send_pcm(n);
		end else if (kind < 39) begin
			// oversized data chunk, cut off by the next file start
			send_word(DATA_TAG);
			send_word($urandom() | 32'h40);
			send_pcm($urandom_range(2, 30));
		end else begin
			repeat ($urandom_range(0, 3))
				send_skip_chunk($urandom_range(0, 24));
			n = $urandom_range(1, 40);
			send_word(DATA_TAG);
			send_word(n);
			send_pcm(n);
			send_trailer();
		end
	endtask

	task automatic drain();
		while (bytes_taken != bytes_queued || pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// byte driver and output back-pressure
	always @(negedge clk) begin
		wav_beat_t nxt;
		m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || byte_fire) begin
			if (file_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = file_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= nxt.data;
				s_axis_tuser  <= nxt.start;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// beat monitor, prediction and compare
	always @(posedge clk) begin
		stereo_out_t got, want;
		byte_fire <= s_axis_tvalid && s_axis_tready;
		if (cfg_valid && cfg_ready) begin
			gain_now = cfg_data;
			gain_writes++;
		end
		if (s_axis_tvalid && s_axis_tready) begin
			parse_wav_byte(s_axis_tdata, s_axis_tuser[0]);
			bytes_taken++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{code: rcode_t'(m_axis_tuser), left: m_axis_tdata[15:0],
				right: m_axis_tdata[31:16], last: m_axis_tlast};
			if (pending_results.size() != 0)
				want = pending_results.pop_front();
			else
				want = 'x;
			if (got !== want) begin
				if (mismatches < 10) begin
					$write("mismatch: expected code %0d L %0d R %0d last %b, ",
						want.code, $signed(want.left), $signed(want.right), want.last);
					$display("got code %0d L %0d R %0d last %b",
						got.code, $signed(got.left), $signed(got.right), got.last);
				end
				mismatches++;
			end
			case (got.code)
				RC_SAMPLE:   samples_seen++;
				RC_NOT_RIFF: riff_errors++;
				RC_NO_DATA:  data_errors++;
				default: ;
			endcase
			if (got.last)
				lasts_seen++;
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [7:0] gain_plan [8];
		int         w, target;
		gain_plan = '{8'd255, 8'd0, 8'd1, 8'd100, 8'd99, 8'd101, 8'd0, 8'd0};
		gain_plan[6] = 8'($urandom_range(2, 98));
		gain_plan[7] = 8'($urandom_range(102, 254));
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// idle bytes, wrong magic, empty data chunk
		send_byte(8'h00);
		send_byte(8'hff);
		stray_bytes += 2;
		send_word(32'h5846_4952, 1'b1);
		send_word(RIFF_WORD, 1'b1);
		send_filler(8);
		send_word(DATA_TAG);
		send_word(32'd0);
		files_sent += 2;

		for (int p = 0; p <= 8; p++) begin
			if (p > 0) begin
				drain();
				cfg_valid <= 1'b1;
				cfg_data  <= gain_plan[p - 1];
				w = gain_writes;
				while (gain_writes == w)
					@(negedge clk);
				cfg_valid <= 1'b0;
			end
			calm = (p == 4);
			target = bytes_queued - stray_bytes + PHASE_BYTES;
			while (bytes_queued - stray_bytes < target)
				add_random_file();
		end
		drain();

		$display("run covered %0d files in %0d bytes over %0d gain writes", files_sent,
			bytes_taken, gain_writes);
		$display("results: %0d samples (%0d flagged last), %0d not-RIFF, %0d no-data",
			samples_seen, lasts_seen, riff_errors, data_errors);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
design/wdcs_pkg.sv
design/wdcs_parse.sv
design/wdcs_gain.sv
design/wav_data_chunk_stream_gain_top.sv
test/testbench.sv
